[rtl/core/lks_pkg.sv]
// ----------------------------------------------------------------------------
// lks_pkg
// Shared types and constants for the keyed store with write-recency eviction.
// ----------------------------------------------------------------------------
package lks_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_W     = 64;
    localparam int DATA_W    = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int RANK_W    = IDX_W;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CTR_W     = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_RESET = 64;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_SAVE   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              operation;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] write_data;
    } t_cmd;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_data;
        logic [CTR_W-1:0]  lookups_total;
        logic [CTR_W-1:0]  hits_total;
        logic [CNT_W-1:0]  occupancy;
    } t_result;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic [RANK_W-1:0] rank;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic [IDX_W-1:0]  wr_addr;
        logic              wr_entry;
        logic              wr_rank_en;
        logic [KEY_W-1:0]  wr_key;
        logic [DATA_W-1:0] wr_value;
        logic [RANK_W-1:0] wr_rank;
    } t_mem_req;

endpackage

[rtl/core/lks_store.sv]
// ----------------------------------------------------------------------------
// lks_store
// Entry storage: key, value and age rank arrays, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module lks_store (
    input  logic              i_clk,
    input  lks_pkg::t_mem_req i_req,
    output lks_pkg::t_entry   o_rd
);

    logic [lks_pkg::KEY_W-1:0]  r_key_mem  [lks_pkg::CAPACITY];
    logic [lks_pkg::DATA_W-1:0] r_val_mem  [lks_pkg::CAPACITY];
    logic [lks_pkg::RANK_W-1:0] r_rank_mem [lks_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_entry) begin
            r_key_mem[i_req.wr_addr] <= i_req.wr_key;
            r_val_mem[i_req.wr_addr] <= i_req.wr_value;
        end
        if (i_req.wr_rank_en) begin
            r_rank_mem[i_req.wr_addr] <= i_req.wr_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd.key   <= r_key_mem[i_req.rd_addr];
        o_rd.value <= r_val_mem[i_req.rd_addr];
        o_rd.rank  <= r_rank_mem[i_req.rd_addr];
    end

endmodule

[rtl/core/lks_ctrl.sv]
// ----------------------------------------------------------------------------
// lks_ctrl
// Sequencer: search pass over all entries, then a rank update pass on saves,
// with valid bits, occupancy and the saturating request counters.
// ----------------------------------------------------------------------------
module lks_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  lks_pkg::t_cmd              i_cmd,
    input  logic [lks_pkg::CNT_W-1:0]  i_eff_cap,
    input  lks_pkg::t_entry            i_rd,
    output lks_pkg::t_mem_req          o_mem,
    output logic                       o_busy,
    output logic                       o_strobe,
    output lks_pkg::t_result           o_result
);

    localparam int IDX_W  = lks_pkg::IDX_W;
    localparam int CNT_W  = lks_pkg::CNT_W;
    localparam int RANK_W = lks_pkg::RANK_W;
    localparam int CTR_W  = lks_pkg::CTR_W;

    lks_pkg::t_state r_state, n_state;
    lks_pkg::t_cmd   r_cmd, n_cmd;
    logic [CNT_W-1:0]           r_addr, n_addr;
    logic                       r_pipe_vld, n_pipe_vld;
    logic [IDX_W-1:0]           r_pipe_idx, n_pipe_idx;
    logic [lks_pkg::CAPACITY-1:0] r_valid, n_valid;
    logic                       r_found, n_found;
    logic [IDX_W-1:0]           r_slot, n_slot;
    logic [RANK_W-1:0]          r_slot_rank, n_slot_rank;
    logic [lks_pkg::DATA_W-1:0] r_rdata, n_rdata;
    logic [IDX_W-1:0]           r_victim, n_victim;
    logic                       r_free_found, n_free_found;
    logic [IDX_W-1:0]           r_free, n_free;
    logic                       r_evict, n_evict;
    logic [IDX_W-1:0]           r_ins, n_ins;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CTR_W-1:0]           r_lookups, n_lookups;
    logic [CTR_W-1:0]           r_hits, n_hits;
    logic                       r_strobe, n_strobe;
    lks_pkg::t_result           r_result, n_result;

    logic is_save;
    logic issue;
    logic st_v;
    logic st_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lks_pkg::ST_IDLE;
            r_addr       <= '0;
            r_pipe_vld   <= 1'b0;
            r_valid      <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_evict      <= 1'b0;
            r_count      <= '0;
            r_lookups    <= '0;
            r_hits       <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_pipe_vld   <= n_pipe_vld;
            r_valid      <= n_valid;
            r_found      <= n_found;
            r_free_found <= n_free_found;
            r_evict      <= n_evict;
            r_count      <= n_count;
            r_lookups    <= n_lookups;
            r_hits       <= n_hits;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_pipe_idx  <= n_pipe_idx;
        r_slot      <= n_slot;
        r_slot_rank <= n_slot_rank;
        r_rdata     <= n_rdata;
        r_victim    <= n_victim;
        r_free      <= n_free;
        r_ins       <= n_ins;
        r_result    <= n_result;
    end

    assign is_save = (r_cmd.operation == lks_pkg::OP_SAVE);
    assign issue   = (r_addr != CNT_W'(lks_pkg::CAPACITY));
    assign st_v    = r_valid[r_pipe_idx];
    assign st_last = r_pipe_vld && (r_pipe_idx == IDX_W'(lks_pkg::CAPACITY - 1));

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_pipe_vld   = r_pipe_vld;
        n_pipe_idx   = r_pipe_idx;
        n_valid      = r_valid;
        n_found      = r_found;
        n_slot       = r_slot;
        n_slot_rank  = r_slot_rank;
        n_rdata      = r_rdata;
        n_victim     = r_victim;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_evict      = r_evict;
        n_ins        = r_ins;
        n_count      = r_count;
        n_lookups    = r_lookups;
        n_hits       = r_hits;
        n_strobe     = 1'b0;
        n_result     = r_result;

        o_mem.rd_addr    = r_addr[IDX_W-1:0];
        o_mem.wr_addr    = r_pipe_idx;
        o_mem.wr_entry   = 1'b0;
        o_mem.wr_rank_en = 1'b0;
        o_mem.wr_key     = r_cmd.key;
        o_mem.wr_value   = r_cmd.write_data;
        o_mem.wr_rank    = '0;

        unique case (r_state)
            lks_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_cmd        = i_cmd;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_evict      = 1'b0;
                    n_addr       = '0;
                    n_pipe_vld   = 1'b0;
                    n_state      = lks_pkg::ST_SCAN;
                end
            end
            lks_pkg::ST_SCAN: begin
                n_pipe_vld = issue;
                if (issue) begin
                    n_addr     = r_addr + CNT_W'(1);
                    n_pipe_idx = r_addr[IDX_W-1:0];
                end
                if (r_pipe_vld) begin
                    if (st_v && (i_rd.key == r_cmd.key) && !r_found) begin
                        n_found     = 1'b1;
                        n_slot      = r_pipe_idx;
                        n_slot_rank = i_rd.rank;
                        n_rdata     = i_rd.value;
                    end
                    // oldest valid entry holds rank count-1
                    if (st_v && (CNT_W'(i_rd.rank) == r_count - CNT_W'(1))) begin
                        n_victim = r_pipe_idx;
                    end
                    if (!st_v && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free       = r_pipe_idx;
                    end
                end
                if (st_last) begin
                    n_addr     = '0;
                    n_pipe_vld = 1'b0;
                    n_state    = is_save ? lks_pkg::ST_PREP : lks_pkg::ST_DONE;
                end
            end
            lks_pkg::ST_PREP: begin
                n_evict = !r_found && (r_count >= i_eff_cap);
                if (n_evict && (!r_free_found || (r_victim < r_free))) begin
                    n_ins = r_victim;
                end else begin
                    n_ins = r_free;
                end
                n_state = lks_pkg::ST_UPDATE;
            end
            lks_pkg::ST_UPDATE: begin
                n_pipe_vld = issue;
                if (issue) begin
                    n_addr     = r_addr + CNT_W'(1);
                    n_pipe_idx = r_addr[IDX_W-1:0];
                end
                if (r_pipe_vld) begin
                    if (r_found) begin
                        if (r_pipe_idx == r_slot) begin
                            o_mem.wr_entry   = 1'b1;
                            o_mem.wr_rank_en = 1'b1;
                        end else if (st_v && (i_rd.rank < r_slot_rank)) begin
                            o_mem.wr_rank_en = 1'b1;
                            o_mem.wr_rank    = i_rd.rank + RANK_W'(1);
                        end
                    end else begin
                        if (r_pipe_idx == r_ins) begin
                            o_mem.wr_entry      = 1'b1;
                            o_mem.wr_rank_en    = 1'b1;
                            n_valid[r_pipe_idx] = 1'b1;
                        end else if (r_evict && (r_pipe_idx == r_victim)) begin
                            n_valid[r_pipe_idx] = 1'b0;
                        end else if (st_v) begin
                            o_mem.wr_rank_en = 1'b1;
                            o_mem.wr_rank    = i_rd.rank + RANK_W'(1);
                        end
                    end
                end
                if (st_last) begin
                    n_addr     = '0;
                    n_pipe_vld = 1'b0;
                    n_state    = lks_pkg::ST_DONE;
                end
            end
            lks_pkg::ST_DONE: begin
                if (is_save) begin
                    if (!r_found) begin
                        n_count = r_count + CNT_W'(1) - CNT_W'(r_evict);
                    end
                end else begin
                    if (r_lookups != '1) begin
                        n_lookups = r_lookups + CTR_W'(1);
                    end
                    if (r_found && (r_hits != '1)) begin
                        n_hits = r_hits + CTR_W'(1);
                    end
                end
                n_result.hit           = r_found;
                n_result.read_data     = (!is_save && r_found) ? r_rdata : '0;
                n_result.lookups_total = n_lookups;
                n_result.hits_total    = n_hits;
                n_result.occupancy     = n_count;
                n_strobe               = 1'b1;
                n_state                = lks_pkg::ST_IDLE;
            end
            default: begin
                n_state = lks_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != lks_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[rtl/core/lru_keyed_store.sv]
// ----------------------------------------------------------------------------
// lru_keyed_store
// Fully associative 64-entry key/value store, oldest-written entry evicted.
//
// A command beat (operation, key, write_data on i_cmd) is taken when start
// is high and busy is low. A lookup returns hit and the stored data and
// bumps the saturating lookup counter and, on a hit, the hit counter; a save
// inserts or updates the key and makes it the newest entry, evicting the
// oldest when the store already holds the configured capacity. Each command
// yields one result beat on o_result, marked by o_strobe for one cycle; it
// must be taken then. Timing: every command first walks all 64 entries
// through the single read port of the entry store, one entry a cycle. A
// save then runs a second walk to renumber ranks before it answers. busy
// is high from acceptance until the result beat, and a new command may be
// taken in the cycle the result is shown.
// i_cfg_we with i_cfg_wdata sets the capacity (0 acts as 1, above 64 as 64);
// write it only while busy is low. Reset empties the store, clears the
// counters and sets the capacity to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_keyed_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  lks_pkg::t_cmd             i_cmd,
    input  logic                      i_cfg_we,
    input  logic [lks_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                      busy,
    output logic                      o_strobe,
    output lks_pkg::t_result          o_result
);

    logic [lks_pkg::CFG_W-1:0] r_cap;
    logic [lks_pkg::CNT_W-1:0] eff_cap;
    lks_pkg::t_mem_req         mem_req;
    lks_pkg::t_entry           mem_rd;
    logic                      accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lks_pkg::CFG_W'(lks_pkg::CFG_RESET);
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = lks_pkg::CNT_W'(1);
        end else if (32'(r_cap) > 32'(lks_pkg::CAPACITY)) begin
            eff_cap = lks_pkg::CNT_W'(lks_pkg::CAPACITY);
        end else begin
            eff_cap = lks_pkg::CNT_W'(r_cap);
        end
    end

    assign accept = start && !busy;

    lks_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_cmd     (i_cmd),
        .i_eff_cap (eff_cap),
        .i_rd      (mem_rd),
        .o_mem     (mem_req),
        .o_busy    (busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    lks_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rd  (mem_rd)
    );

endmodule
